FILE: rtl/core/tcp_connection_lookup_table_defines.svh
`ifndef TCP_CONNECTION_LOOKUP_TABLE_DEFINES_SVH
`define TCP_CONNECTION_LOOKUP_TABLE_DEFINES_SVH

// Same-cycle implication check.
`define TCL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check.
`define TCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tcl_pkg.sv
`default_nettype none

package tcl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int HANDLE_W = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int TUPLE_W  = 96;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADH     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PASS_A,
    S_PASS_B,
    S_DONE
  } state_e;

  // One decoded command word as it sits in the queue.
  typedef struct packed {
    op_e                 op;
    logic                uniq;
    logic [TUPLE_W-1:0]  tuple;     // {ip_src, ip_dst, source port, destination port}
    logic [HANDLE_W-1:0] handle;
    logic                handle_ok; // handle below table size
  } cmd_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic valid;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic hold; // table clear in progress
  } q_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcl_front.sv
`default_nettype none

module tcl_front #(
  parameter int TABLE_ENTRIES = tcl_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic                          check_unique_i,
  input  wire logic [31:0]                   ip_src_i,
  input  wire logic [31:0]                   ip_dst_i,
  input  wire logic [15:0]                   tcp_sport_i,
  input  wire logic [15:0]                   tcp_dport_i,
  input  wire logic [tcl_pkg::HANDLE_W-1:0]  entry_handle_i,
  output tcl_pkg::cmd_t                      cmd_o,
  output tcl_pkg::q_stat_t                   q_stat_o,
  input  wire tcl_pkg::q_ctrl_t              q_ctrl_i
);

  tcl_pkg::cmd_t fifo_q [2];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  tcl_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.op        = tcl_pkg::op_e'(func_i);
    cmd_in.uniq      = check_unique_i;
    cmd_in.tuple     = {ip_src_i, ip_dst_i, tcp_sport_i, tcp_dport_i};
    cmd_in.handle    = entry_handle_i;
    cmd_in.handle_ok = 32'(entry_handle_i) < 32'(TABLE_ENTRIES);
  end

  assign in_stall_o     = (cnt_q == 2'd2) || q_ctrl_i.hold;
  assign push           = in_valid_i && !in_stall_o;
  assign cmd_o          = fifo_q[rd_q];
  assign q_stat_o.valid = (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = q_ctrl_i.pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_ctrl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcl_back.sv
`default_nettype none

`include "tcp_connection_lookup_table_defines.svh"

module tcl_back #(
  parameter int TABLE_ENTRIES = tcl_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tcl_pkg::cmd_t                 cmd_i,
  input  wire tcl_pkg::q_stat_t              q_stat_i,
  output tcl_pkg::q_ctrl_t                   q_ctrl_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tcl_pkg::STATUS_W-1:0]       status_o,
  output logic [tcl_pkg::HANDLE_W-1:0]       result_handle_o,
  output logic [tcl_pkg::COUNT_W-1:0]        entry_count_o
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int TW = tcl_pkg::TUPLE_W;
  localparam int EW = 1 + IW + TW;
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  // entry: {valid, age rank, tuple}
  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  tcl_pkg::state_e state_q, state_d;
  tcl_pkg::cmd_t   cur_q, cur_d;
  logic [IW-1:0]   iss_q, iss_d, proc_idx_q, proc_idx_d;
  logic            iss_on_q, iss_on_d, proc_vld_q, proc_vld_d;
  logic            hit_q, hit_d, free_q, free_d, hv_q, hv_d;
  logic [IW-1:0]   hit_idx_q, hit_idx_d, hit_rank_q, hit_rank_d;
  logic [IW-1:0]   free_idx_q, free_idx_d, hrank_q, hrank_d;
  logic [CW-1:0]   count_q, count_d;
  tcl_pkg::status_e res_st_q, res_st_d;
  logic [IW-1:0]   res_h_q, res_h_d;
  logic            out_valid_q, out_valid_d;
  logic [tcl_pkg::STATUS_W-1:0] out_st_q;
  logic [tcl_pkg::HANDLE_W-1:0] out_h_q;
  logic [tcl_pkg::COUNT_W-1:0]  out_cnt_q;

  logic          e_v, pass_end, need_b, out_free, load_out;
  logic [IW-1:0] e_r, hidx;
  logic [TW-1:0] e_t;
  logic          e_match;

  assign e_v      = rd_q[EW-1];
  assign e_r      = rd_q[EW-2 -: IW];
  assign e_t      = rd_q[TW-1:0];
  assign e_match  = e_v && (e_t == cur_q.tuple);
  assign hidx     = IW'(cur_q.handle);
  assign pass_end = proc_vld_q && (proc_idx_q == LAST);
  assign out_free = !out_valid_q || !out_stall_i;

  // Scan datapath: pass A classifies, pass B rewrites ranks and the slot.
  always_comb begin
    iss_d      = iss_q;
    iss_on_d   = iss_on_q;
    proc_vld_d = 1'b0;
    proc_idx_d = iss_q;
    cur_d      = cur_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_rank_d = hit_rank_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    hv_d       = hv_q;
    hrank_d    = hrank_q;
    count_d    = count_q;
    res_st_d   = res_st_q;
    res_h_d    = res_h_q;
    need_b     = 1'b0;

    if (state_q == tcl_pkg::S_CLEAR) begin
      iss_d = (iss_q == LAST) ? '0 : iss_q + IW'(1);
    end
    if ((state_q == tcl_pkg::S_PASS_A || state_q == tcl_pkg::S_PASS_B) && iss_on_q) begin
      proc_vld_d = 1'b1;
      if (iss_q == LAST) begin
        iss_on_d = 1'b0;
      end else begin
        iss_d = iss_q + IW'(1);
      end
    end
    if (state_q == tcl_pkg::S_IDLE && q_stat_i.valid) begin
      cur_d    = cmd_i;
      iss_d    = '0;
      iss_on_d = 1'b1;
      hit_d    = 1'b0;
      free_d   = 1'b0;
      hv_d     = 1'b0;
    end

    if (state_q == tcl_pkg::S_PASS_A && proc_vld_q) begin
      if (!e_v && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = proc_idx_q;
      end
      if (e_match && (!hit_q || e_r < hit_rank_q)) begin
        hit_d      = 1'b1;
        hit_idx_d  = proc_idx_q;
        hit_rank_d = e_r;
      end
      if (proc_idx_q == hidx) begin
        hv_d    = e_v;
        hrank_d = e_r;
      end
    end

    if (state_q == tcl_pkg::S_PASS_A && pass_end) begin
      res_h_d  = '0;
      res_st_d = tcl_pkg::ST_OK;
      case (cur_q.op)
        tcl_pkg::OP_INSERT: begin
          if (cur_q.uniq && hit_d) begin
            res_st_d = tcl_pkg::ST_DUP;
          end else if (!free_d) begin
            res_st_d = tcl_pkg::ST_FULL;
          end else begin
            need_b = 1'b1;
          end
        end
        tcl_pkg::OP_REMOVE: begin
          if (!cur_q.handle_ok || !hv_d) begin
            res_st_d = tcl_pkg::ST_BADH;
          end else begin
            need_b = 1'b1;
          end
        end
        tcl_pkg::OP_LOOKUP: begin
          if (hit_d) begin
            res_h_d = hit_idx_d;
          end else begin
            res_st_d = tcl_pkg::ST_NOTFOUND;
          end
        end
        default: ;
      endcase
      if (need_b) begin
        iss_d    = '0;
        iss_on_d = 1'b1;
      end
    end

    if (state_q == tcl_pkg::S_PASS_B && pass_end) begin
      res_st_d = tcl_pkg::ST_OK;
      if (cur_q.op == tcl_pkg::OP_INSERT) begin
        res_h_d = free_idx_q;
        count_d = count_q + CW'(1);
      end else begin
        res_h_d = hidx;
        count_d = count_q - CW'(1);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcl_pkg::S_CLEAR:  if (iss_q == LAST) state_d = tcl_pkg::S_IDLE;
      tcl_pkg::S_IDLE:   if (q_stat_i.valid) state_d = tcl_pkg::S_PASS_A;
      tcl_pkg::S_PASS_A: if (pass_end) state_d = need_b ? tcl_pkg::S_PASS_B : tcl_pkg::S_DONE;
      tcl_pkg::S_PASS_B: if (pass_end) state_d = tcl_pkg::S_DONE;
      tcl_pkg::S_DONE:   if (out_free) state_d = tcl_pkg::S_IDLE;
      default:           state_d = tcl_pkg::S_CLEAR;
    endcase
  end

  // State outputs: queue control, memory writes, result load.
  always_comb begin
    q_ctrl_o.pop  = 1'b0;
    q_ctrl_o.hold = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = proc_idx_q;
    mem_wd        = rd_q;
    load_out      = 1'b0;
    unique case (state_q)
      tcl_pkg::S_CLEAR: begin
        q_ctrl_o.hold = 1'b1;
        mem_we        = 1'b1;
        mem_wa        = iss_q;
        mem_wd        = '0;
      end
      tcl_pkg::S_IDLE: q_ctrl_o.pop = q_stat_i.valid;
      tcl_pkg::S_PASS_B: begin
        if (proc_vld_q) begin
          if (cur_q.op == tcl_pkg::OP_INSERT) begin
            if (proc_idx_q == free_idx_q) begin
              mem_we = 1'b1;
              mem_wd = {1'b1, IW'(0), cur_q.tuple};
            end else if (e_v) begin
              mem_we = 1'b1;
              mem_wd = {1'b1, e_r + IW'(1), e_t};
            end
          end else begin
            if (proc_idx_q == hidx) begin
              mem_we = 1'b1;
              mem_wd = {1'b0, e_r, e_t};
            end else if (e_v && e_r > hrank_q) begin
              mem_we = 1'b1;
              mem_wd = {1'b1, e_r - IW'(1), e_t};
            end
          end
        end
      end
      tcl_pkg::S_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcl_pkg::S_CLEAR;
      iss_q       <= '0;
      iss_on_q    <= 1'b0;
      proc_vld_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      iss_on_q    <= iss_on_d;
      proc_vld_q  <= proc_vld_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= proc_idx_d;
    cur_q      <= cur_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    hv_q       <= hv_d;
    hrank_q    <= hrank_d;
    res_st_q   <= res_st_d;
    res_h_q    <= res_h_d;
    if (load_out) begin
      out_st_q  <= res_st_q;
      out_h_q   <= tcl_pkg::HANDLE_W'(res_h_q);
      out_cnt_q <= tcl_pkg::COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[iss_q];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign result_handle_o = out_h_q;
  assign entry_count_o   = out_cnt_q;

  `TCL_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(TABLE_ENTRIES), "count over table size")
  `TCL_ASSERT_NOW(a_ins_has_free, clk_i, rst_ni, state_q == tcl_pkg::S_PASS_B && cur_q.op == tcl_pkg::OP_INSERT, free_q, "insert rewrite without free slot")
  `TCL_ASSERT_NOW(a_rem_has_slot, clk_i, rst_ni, state_q == tcl_pkg::S_PASS_B && cur_q.op == tcl_pkg::OP_REMOVE, hv_q && cur_q.handle_ok, "remove rewrite of free slot")
  `TCL_ASSERT_NEXT(a_pop_starts, clk_i, rst_ni, q_ctrl_o.pop, state_q == tcl_pkg::S_PASS_A, "pop did not start a scan")

endmodule

`default_nettype wire

FILE: rtl/core/tcp_connection_lookup_table.sv
`default_nettype none

// TCP four-tuple connection table, fully associative. Insert puts the tuple in
// the lowest free slot and returns it as the handle (refused with a duplicate
// status when check_unique is set and the tuple is present, or full status);
// remove frees a slot by handle; lookup returns the newest matching entry by
// age rank. All entries live in one synchronous memory that the back end
// scans one entry per cycle: lookup, refused or failed operations take one
// scan, and a successful insert or remove takes a second scan that rewrites
// the ranks. A two-word queue in front takes words while the scan runs, and
// a result register holds the answer until taken. After reset the memory is
// cleared, and in_stall_o stays high while it is.
module tcp_connection_lookup_table #(
  parameter int TABLE_ENTRIES = tcl_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic                          check_unique_i,
  input  wire logic [31:0]                   ip_src_i,
  input  wire logic [31:0]                   ip_dst_i,
  input  wire logic [15:0]                   tcp_sport_i,
  input  wire logic [15:0]                   tcp_dport_i,
  input  wire logic [tcl_pkg::HANDLE_W-1:0]  entry_handle_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tcl_pkg::STATUS_W-1:0]       status_o,
  output logic [tcl_pkg::HANDLE_W-1:0]       result_handle_o,
  output logic [tcl_pkg::COUNT_W-1:0]        entry_count_o
);

  tcl_pkg::cmd_t    cmd;
  tcl_pkg::q_stat_t q_stat;
  tcl_pkg::q_ctrl_t q_ctrl;

  // Front: decode and queue incoming words.
  tcl_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .check_unique_i,
    .ip_src_i,
    .ip_dst_i,
    .tcp_sport_i,
    .tcp_dport_i,
    .entry_handle_i,
    .cmd_o    (cmd),
    .q_stat_o (q_stat),
    .q_ctrl_i (q_ctrl)
  );

  // Back: memory scan, rank upkeep and result register.
  tcl_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .q_stat_i (q_stat),
    .q_ctrl_o (q_ctrl),
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .result_handle_o,
    .entry_count_o
  );

endmodule

`default_nettype wire
